// ===== design/rcfb_pkg.sv =====
`timescale 1ns / 1ps

package rcfb_pkg;

    localparam int NUM_CHANNELS_DEF = 16;

    localparam int PULSE_W   = 12;
    localparam int GAIN_W    = 24;
    localparam int OFFSET_W  = 32;
    localparam int PROD_W    = GAIN_W + PULSE_W;
    localparam int VALUE_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_OFFSET = 2'd1;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd104814;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'hFA81_5AD8;

    localparam logic [BYTE_W-1:0] HEADER_BYTE  = 8'h0F;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h00;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [OFFSET_W-1:0] offset;
    } map_cfg_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } map_item_t;

endpackage

// ===== design/rcfb_cfg.sv =====
`timescale 1ns / 1ps

module rcfb_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfb_pkg::CFG_DAT_W-1:0]  cfg_data,
    output rcfb_pkg::map_cfg_t              map_cfg
);

    logic [rcfb_pkg::GAIN_W-1:0]   gain_reg;
    logic [rcfb_pkg::OFFSET_W-1:0] offset_reg;

    assign cfg_ready = 1'b1;

    // Unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= rcfb_pkg::GAIN_RESET;
            offset_reg <= rcfb_pkg::OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == rcfb_pkg::CFG_MAP_GAIN)
            begin
                gain_reg <= cfg_data[rcfb_pkg::GAIN_W-1:0];
            end
            if (cfg_index == rcfb_pkg::CFG_MAP_OFFSET)
            begin
                offset_reg <= cfg_data[rcfb_pkg::OFFSET_W-1:0];
            end
        end
    end

    assign map_cfg.gain   = gain_reg;
    assign map_cfg.offset = offset_reg;

endmodule

// ===== design/rcfb_map.sv =====
`timescale 1ns / 1ps

module rcfb_map
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rcfb_pkg::PULSE_W-1:0]   pulse_value,
    input  rcfb_pkg::map_cfg_t             map_cfg,
    output rcfb_pkg::map_item_t            item,
    input  logic                           item_ready
);

    logic                               a_valid_reg;
    logic [rcfb_pkg::PULSE_W-1:0]       a_pulse_reg;
    logic                               b_valid_reg;
    logic [rcfb_pkg::OFFSET_W-1:0]      b_prod_reg;
    logic [rcfb_pkg::PROD_W-1:0]        prod_full;
    logic [rcfb_pkg::OFFSET_W-1:0]      sum;
    logic                               b_ready;
    logic                               a_ready;
    logic                               a_adv;

    assign b_ready  = !b_valid_reg || item_ready;
    assign a_adv    = a_valid_reg && b_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_stall = !a_ready;

    assign prod_full = rcfb_pkg::PROD_W'(map_cfg.gain) * rcfb_pkg::PROD_W'(a_pulse_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_pulse_reg <= pulse_value;
        end
        // Only the low 32 bits of the product reach the sent value.
        if (a_adv)
        begin
            b_prod_reg <= prod_full[rcfb_pkg::OFFSET_W-1:0];
        end
    end

    assign sum        = b_prod_reg + map_cfg.offset;
    assign item.valid = b_valid_reg;
    assign item.value = sum[rcfb_pkg::OFFSET_W-1 -: rcfb_pkg::VALUE_W];

endmodule

// ===== design/rcfb_framer.sv =====
`timescale 1ns / 1ps

module rcfb_framer
#(
    parameter int NUM_CHANNELS = rcfb_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcfb_pkg::map_item_t           item,
    output logic                          item_ready,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rcfb_pkg::BYTE_W-1:0]   out_byte,
    output logic                          run_last,
    output logic                          frame_end
);

    localparam logic [rcfb_pkg::SLOT_W:0]   NUM_SLOTS = (rcfb_pkg::SLOT_W+1)'(NUM_CHANNELS);
    localparam logic [rcfb_pkg::SLOT_W-1:0] LAST_SLOT = rcfb_pkg::SLOT_W'(NUM_CHANNELS - 1);

    logic [rcfb_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [rcfb_pkg::BYTE_W-1:0]  xor_reg, xor_next;
    logic [rcfb_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rcfb_pkg::BYTE_W-1:0]  bytes_reg [rcfb_pkg::MAX_BYTES];
    logic [rcfb_pkg::BYTE_W-1:0]  bytes_next [rcfb_pkg::MAX_BYTES];
    logic                         fend_reg, fend_next;

    logic [rcfb_pkg::SLOT_W-1:0]  slot_eff;
    logic                         is_first;
    logic                         is_last;
    logic [rcfb_pkg::BYTE_W-1:0]  hi_byte;
    logic [rcfb_pkg::BYTE_W-1:0]  lo_byte;
    logic [rcfb_pkg::BYTE_W-1:0]  xor_base;
    logic [rcfb_pkg::BYTE_W-1:0]  xor_run;
    logic [rcfb_pkg::BYTE_W-1:0]  chk_byte;
    logic                         pop;
    logic                         load;

    assign pop        = out_valid && !out_stall;
    assign item_ready = (cnt_reg == '0) || ((cnt_reg == rcfb_pkg::CNT_W'(1)) && pop);
    assign load       = item.valid && item_ready;

    assign slot_eff = ({1'b0, slot_reg} >= NUM_SLOTS) ? '0 : slot_reg;
    assign is_first = (slot_eff == '0);
    assign is_last  = (slot_eff == LAST_SLOT);
    assign hi_byte  = item.value[rcfb_pkg::VALUE_W-1 -: rcfb_pkg::BYTE_W];
    assign lo_byte  = item.value[rcfb_pkg::BYTE_W-1:0];
    assign xor_base = is_first ? '0 : xor_reg;
    assign xor_run  = xor_base ^ hi_byte ^ lo_byte;
    assign chk_byte = (NUM_CHANNELS > 1) ? (xor_run ^ rcfb_pkg::TRAILER_BYTE) : xor_run;

    always_comb
    begin
        slot_next = slot_reg;
        xor_next  = xor_reg;
        cnt_next  = cnt_reg;
        fend_next = fend_reg;
        for (int i = 0; i < rcfb_pkg::MAX_BYTES; i++)
        begin
            bytes_next[i] = bytes_reg[i];
        end

        if (load)
        begin
            slot_next = is_last ? '0 : slot_eff + rcfb_pkg::SLOT_W'(1);
            xor_next  = is_last ? '0 : xor_run;
            fend_next = is_last;
            bytes_next[3] = chk_byte;
            if (is_first && is_last)
            begin
                // single channel: header, value, checksum, no trailer
                bytes_next[0] = rcfb_pkg::HEADER_BYTE;
                bytes_next[1] = hi_byte;
                bytes_next[2] = lo_byte;
                cnt_next      = rcfb_pkg::CNT_W'(4);
            end
            else if (is_first)
            begin
                bytes_next[0] = rcfb_pkg::HEADER_BYTE;
                bytes_next[1] = hi_byte;
                bytes_next[2] = lo_byte;
                cnt_next      = rcfb_pkg::CNT_W'(3);
            end
            else if (is_last)
            begin
                bytes_next[0] = hi_byte;
                bytes_next[1] = lo_byte;
                bytes_next[2] = rcfb_pkg::TRAILER_BYTE;
                cnt_next      = rcfb_pkg::CNT_W'(4);
            end
            else
            begin
                bytes_next[0] = hi_byte;
                bytes_next[1] = lo_byte;
                bytes_next[2] = lo_byte;
                cnt_next      = rcfb_pkg::CNT_W'(2);
            end
        end
        else if (pop)
        begin
            // advance the byte queue
            for (int i = 0; i < rcfb_pkg::MAX_BYTES - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
            cnt_next = cnt_reg - rcfb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            xor_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            xor_reg  <= xor_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fend_reg <= fend_next;
        for (int i = 0; i < rcfb_pkg::MAX_BYTES; i++)
        begin
            bytes_reg[i] <= bytes_next[i];
        end
    end

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = bytes_reg[0];
    assign run_last  = (cnt_reg == rcfb_pkg::CNT_W'(1));
    assign frame_end = run_last && fend_reg;

endmodule

// ===== design/rc_channel_frame_builder_top.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// input    | in_valid / in_stall    | pulse_value[11:0]
// output   | out_valid / out_stall  | out_byte[7:0], run_last, frame_end
// config   | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[31:0]
//
// Each channel value yields 2 to 4 bytes: 3 on the first slot, 2 on middle
// slots, 4 on the last; the output byte queue drains one byte per cycle
// while out_stall is low. The first byte passes the input reg, product reg
// and framer byte queue. Reset clears the slot counter, the running XOR and
// the byte queue; the map registers return to their defaults. A stalled
// output backs up through the product and input registers into in_stall.
module rc_channel_frame_builder_top
#(
    parameter int NUM_CHANNELS = rcfb_pkg::NUM_CHANNELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rcfb_pkg::PULSE_W-1:0]   pulse_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rcfb_pkg::BYTE_W-1:0]    out_byte,
    output logic                           run_last,
    output logic                           frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcfb_pkg::CFG_DAT_W-1:0] cfg_data
);

    rcfb_pkg::map_cfg_t  map_cfg;
    rcfb_pkg::map_item_t item;
    logic                item_ready;

    rcfb_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map_cfg   (map_cfg)
    );

    rcfb_map u_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pulse_value (pulse_value),
        .map_cfg     (map_cfg),
        .item        (item),
        .item_ready  (item_ready)
    );

    rcfb_framer #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_framer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_ready (item_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

endmodule

// ===== design/rcfb_checker.sv =====
`timescale 1ns / 1ps

module rcfb_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [rcfb_pkg::PULSE_W-1:0]   pulse_value,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [rcfb_pkg::BYTE_W-1:0]    out_byte,
    input logic                           run_last,
    input logic                           frame_end
);

    // A stalled input transaction holds.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(pulse_value))
        else $error("input changed while stalled");

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(frame_end))
        else $error("output changed while stalled");

    // The checksum byte closes the bytes of its input transaction.
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame end without run last");

    // The byte right after a frame end is the next frame's header.
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && frame_end) ##1 out_valid
            |-> out_byte == rcfb_pkg::HEADER_BYTE)
        else $error("frame does not start with header");

    // With the output empty, nothing can hold back the input.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

endmodule

bind rc_channel_frame_builder_top rcfb_checker u_rcfb_checker (.*);
